/* rtl/rgb2hsv_pkg.sv */
// Shared types and constants for the 8-bit RGB to HSV converter.
// Used by every module under rtl; depends on nothing.
package rgb2hsv_pkg;

  localparam logic [7:0] HUE_BASE_RED   = 8'd0;
  localparam logic [7:0] HUE_BASE_GREEN = 8'd85;
  localparam logic [7:0] HUE_BASE_BLUE  = 8'd171;
  localparam int unsigned DIV_STEPS     = 8;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_pix_t;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } hsv_pix_t;

  typedef struct packed {
    logic [7:0] rem;
    logic [7:0] dvd_lo;
    logic [7:0] dvsr;
    logic [7:0] quo;
  } div_lane_t;

  typedef struct packed {
    div_lane_t  sat;
    div_lane_t  hue;
    logic [7:0] brightness;
    sector_t    sector;
    logic       neg;
    logic       grey;
    logic       black;
  } cell_data_t;

endpackage

/* rtl/rgb_to_hsv_8bit.sv */
// 8-bit RGB to HSV converter: front stage, a chain of eight divider cells
// (one quotient bit each for saturation and hue), and an output register.
// Throughput: one pixel per cycle; each stage stalls only when full and blocked.
// Reset (rst_n low, synchronous) empties every stage; no results pending.
// Depends on rgb2hsv_pkg, rgb2hsv_front, rgb2hsv_cell, rgb2hsv_back.
module rgb_to_hsv_8bit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rgb2hsv_pkg::rgb_pix_t in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rgb2hsv_pkg::hsv_pix_t out_data
);
  import rgb2hsv_pkg::*;

  logic       chain_valid [DIV_STEPS+1];
  logic       chain_ready [DIV_STEPS+1];
  cell_data_t chain_data  [DIV_STEPS+1];

  rgb2hsv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_data  (chain_data[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
    rgb2hsv_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_data   (chain_data[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_data  (chain_data[i+1])
    );
  end

  rgb2hsv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chain_valid[DIV_STEPS]),
    .in_ready  (chain_ready[DIV_STEPS]),
    .in_data   (chain_data[DIV_STEPS]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* rtl/rgb2hsv_front.sv */
// Front stage: channel max/min, sector pick, and divider operand setup.
// Depends on rgb2hsv_pkg.
module rgb2hsv_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  rgb2hsv_pkg::rgb_pix_t   in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output rgb2hsv_pkg::cell_data_t out_data
);
  import rgb2hsv_pkg::*;

  logic       valid_r;
  logic [7:0] mx_r, delta_r, mag_r;
  logic       neg_r;
  sector_t    sector_r;

  logic [7:0] mx_nxt, mn_nxt, delta_nxt, mag_nxt;
  logic [8:0] diff_nxt;
  sector_t    sector_nxt;
  logic [15:0] sat_dvd, hue_dvd;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;

  always_comb begin
    if (in_data.red >= in_data.green && in_data.red >= in_data.blue) begin
      sector_nxt = SEC_RED;
      mx_nxt     = in_data.red;
      diff_nxt   = {1'b0, in_data.green} - {1'b0, in_data.blue};
    end else if (in_data.green >= in_data.blue) begin
      sector_nxt = SEC_GREEN;
      mx_nxt     = in_data.green;
      diff_nxt   = {1'b0, in_data.blue} - {1'b0, in_data.red};
    end else begin
      sector_nxt = SEC_BLUE;
      mx_nxt     = in_data.blue;
      diff_nxt   = {1'b0, in_data.red} - {1'b0, in_data.green};
    end
    mn_nxt = (in_data.red < in_data.green) ? in_data.red : in_data.green;
    if (in_data.blue < mn_nxt) begin
      mn_nxt = in_data.blue;
    end
    delta_nxt = mx_nxt - mn_nxt;
    mag_nxt   = diff_nxt[8] ? 8'(-diff_nxt) : diff_nxt[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      mx_r     <= mx_nxt;
      delta_r  <= delta_nxt;
      mag_r    <= mag_nxt;
      neg_r    <= diff_nxt[8];
      sector_r <= sector_nxt;
    end
  end

  always_comb begin
    sat_dvd = {delta_r, 8'd0} - {8'd0, delta_r};
    hue_dvd = ({8'd0, mag_r} << 5) + ({8'd0, mag_r} << 3)
            + ({8'd0, mag_r} << 1) + {8'd0, mag_r};
    out_data.sat.rem    = sat_dvd[15:8];
    out_data.sat.dvd_lo = sat_dvd[7:0];
    out_data.sat.dvsr   = mx_r;
    out_data.sat.quo    = 8'd0;
    out_data.hue.rem    = hue_dvd[15:8];
    out_data.hue.dvd_lo = hue_dvd[7:0];
    out_data.hue.dvsr   = delta_r;
    out_data.hue.quo    = 8'd0;
    out_data.brightness = mx_r;
    out_data.sector     = sector_r;
    out_data.neg        = neg_r;
    out_data.grey       = (delta_r == 8'd0);
    out_data.black      = (mx_r == 8'd0);
  end

endmodule

/* rtl/rgb2hsv_cell.sv */
// Divider cell: one restoring quotient bit for the saturation and hue lanes.
// Depends on rgb2hsv_pkg.
module rgb2hsv_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  rgb2hsv_pkg::cell_data_t in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output rgb2hsv_pkg::cell_data_t out_data
);
  import rgb2hsv_pkg::*;

  logic       valid_r;
  cell_data_t data_r;
  cell_data_t data_nxt;

  function automatic div_lane_t div_step(div_lane_t lane);
    logic [8:0] trial;
    logic       ge;
    div_lane_t  res;
    trial      = {lane.rem, lane.dvd_lo[7]};
    ge         = (trial >= {1'b0, lane.dvsr});
    res        = lane;
    res.rem    = ge ? 8'(trial - {1'b0, lane.dvsr}) : trial[7:0];
    res.dvd_lo = {lane.dvd_lo[6:0], 1'b0};
    res.quo    = {lane.quo[6:0], ge};
    return res;
  endfunction

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    data_nxt     = in_data;
    data_nxt.sat = div_step(in_data.sat);
    data_nxt.hue = div_step(in_data.hue);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* rtl/rgb2hsv_back.sv */
// Output stage: hue sector sum, black/grey forcing, and the result register.
// Depends on rgb2hsv_pkg.
module rgb2hsv_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  rgb2hsv_pkg::cell_data_t in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output rgb2hsv_pkg::hsv_pix_t   out_data
);
  import rgb2hsv_pkg::*;

  logic     valid_r;
  hsv_pix_t data_r;
  hsv_pix_t data_nxt;
  logic [7:0] base;
  logic [7:0] offset;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    unique case (in_data.sector)
      SEC_RED:   base = HUE_BASE_RED;
      SEC_GREEN: base = HUE_BASE_GREEN;
      SEC_BLUE:  base = HUE_BASE_BLUE;
      default:   base = HUE_BASE_RED;
    endcase
    offset = in_data.neg ? 8'(-in_data.hue.quo) : in_data.hue.quo;
    data_nxt.brightness = in_data.brightness;
    if (in_data.black || in_data.grey) begin
      data_nxt.hue        = 8'd0;
      data_nxt.saturation = 8'd0;
    end else begin
      data_nxt.hue        = base + offset;
      data_nxt.saturation = in_data.sat.quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule
